FILE: design/rsse_pkg.sv
package rsse_pkg;

    // Codeword geometry
    localparam int MAX_PARITY = 32;
    localparam int CFG_W      = 6;
    localparam int IDX_W      = $clog2(MAX_PARITY);
    localparam int CNT_W      = $clog2(MAX_PARITY + 1);

    localparam logic [CFG_W-1:0] PARITY_RESET = CFG_W'(16);

    // GF(2^8) constants, primitive polynomial 0x11d
    localparam logic [7:0] FIELD_POLY_LOW = 8'h1d;
    localparam logic [7:0] FIELD_TOP_BIT  = 8'h80;
    localparam logic [7:0] FIELD_LIMIT    = 8'd255;

    typedef logic [7:0] byte_t;

    // Generator coefficients x^0..x^(MAX_PARITY-1) for each parity count
    typedef logic [MAX_PARITY-1:0][MAX_PARITY-1:0][7:0] gen_tbl_t;

    // Per-cycle control shared by every cell of the parity chain
    typedef struct packed {
        logic step;       // message beat: LFSR update
        logic drain;      // parity beat: shift toward the top stage
        logic clear;      // zero all stages
        logic load_coef;  // take a new generator coefficient
    } rsse_ctrl_t;

    // GF(2^8) multiply, shift-and-add
    function automatic byte_t gmul(input byte_t a, input byte_t b);
        byte_t acc;
        byte_t x;
        acc = '0;
        x   = a;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) begin
                acc = acc ^ x;
            end
            if ((x & FIELD_TOP_BIT) != 8'h00) begin
                x = (x << 1) ^ FIELD_POLY_LOW;
            end else begin
                x = x << 1;
            end
        end
        return acc;
    endfunction

    // Product of (x + alpha^i), i = 0..n-1, for every n in 1..MAX_PARITY
    function automatic gen_tbl_t gen_table();
        gen_tbl_t                tbl;
        logic [MAX_PARITY:0][7:0] g;
        byte_t                   root;
        tbl = '0;
        for (int n = 1; n <= MAX_PARITY; n++) begin
            g    = '0;
            g[0] = 8'h01;
            root = 8'h01;
            for (int i = 0; i < n; i++) begin
                for (int k = i + 1; k > 0; k--) begin
                    g[k] = g[k-1] ^ gmul(g[k], root);
                end
                g[0] = gmul(g[0], root);
                root = gmul(root, 8'h02);
            end
            for (int k = 0; k < MAX_PARITY; k++) begin
                tbl[n-1][k] = g[k];
            end
        end
        return tbl;
    endfunction

    localparam gen_tbl_t GEN_TABLE = gen_table();

    // Parity count clamped to 1..MAX_PARITY, returned as count minus one
    function automatic logic [IDX_W-1:0] eff_top(input logic [CFG_W-1:0] pc);
        logic [IDX_W-1:0] r;
        if (pc == '0) begin
            r = '0;
        end else if (int'(pc) > MAX_PARITY) begin
            r = IDX_W'(MAX_PARITY - 1);
        end else begin
            r = IDX_W'(pc - CFG_W'(1));
        end
        return r;
    endfunction

endpackage

FILE: design/rsse_cell.sv
module rsse_cell import rsse_pkg::*; (
    input  logic       aclk,
    input  rsse_ctrl_t ctrl,
    input  logic       en,
    input  byte_t      prev,
    input  byte_t      fb,
    input  byte_t      coef_in,
    output byte_t      stage
);

    byte_t stage_reg, stage_next;
    byte_t coef_reg;

    // One LFSR stage: cleared by ctrl.clear, update on message beats, shift on parity beats
    always_comb begin
        stage_next = stage_reg;
        if (ctrl.clear) begin
            stage_next = '0;
        end else if (en && ctrl.step) begin
            stage_next = prev ^ gmul(fb, coef_reg);
        end else if (en && ctrl.drain) begin
            stage_next = prev;
        end
    end

    always_ff @(posedge aclk) begin
        stage_reg <= stage_next;
        if (ctrl.load_coef) begin
            coef_reg <= coef_in;
        end
    end

    assign stage = stage_reg;

endmodule

FILE: design/reed_solomon_systematic_encoder_unit.sv
// A message byte appears on the output in the cycle after its input beat.
// Throughput: one byte per cycle, message or parity, unless the output stalls;
//   after the last message byte the n parity bytes drain from the cell chain and
//   s_ready stays low until they have drained (n = parity_count clamped to 1..32).
// Reset (aresetn low, synchronous): parity chain cleared, parity_count = 16,
//   byte count and overflow flag cleared, output empty.
module reed_solomon_systematic_encoder_unit import rsse_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_data_byte,
    input  logic             s_last_of_message,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_code_byte,
    output logic             m_is_parity,
    output logic             m_last_of_codeword,
    output logic             m_too_long,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_parity_count
);

    logic [IDX_W-1:0] top_reg, top_next;
    logic [7:0]       count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic             draining_reg, draining_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic             drain_tl_reg, drain_tl_next;

    logic             m_valid_reg, m_valid_next;
    byte_t            m_code_reg, m_code_next;
    logic             m_par_reg, m_par_next;
    logic             m_last_reg, m_last_next;
    logic             m_tl_reg, m_tl_next;

    logic             out_free, in_beat, par_beat, cfg_beat, final_beat;
    logic [7:0]       count_inc, limit;
    logic             tl;
    logic [IDX_W-1:0] coef_idx;
    byte_t            fb;
    byte_t            stages [MAX_PARITY];
    rsse_ctrl_t       ctrl;

    assign cfg_ready  = 1'b1;
    assign cfg_beat   = cfg_valid && cfg_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign s_ready    = !draining_reg && out_free;
    assign in_beat    = s_valid && s_ready;
    assign par_beat   = draining_reg && out_free;
    assign final_beat = par_beat && (left_reg == CNT_W'(1));

    // Feedback from the top active stage
    assign fb = s_data_byte ^ stages[top_reg];

    // Message length tracking, saturating at 255
    assign count_inc = (count_reg == FIELD_LIMIT) ? count_reg : count_reg + 8'd1;
    assign limit     = FIELD_LIMIT - 8'(top_reg) - 8'd1;
    assign tl        = ovf_reg || (count_inc > limit);

    // Generator row to load on reset or on a config write
    assign coef_idx = !aresetn ? eff_top(PARITY_RESET) : eff_top(cfg_parity_count);

    always_comb begin
        ctrl.step      = in_beat;
        ctrl.drain     = par_beat;
        ctrl.clear     = !aresetn || final_beat;
        ctrl.load_coef = !aresetn || cfg_beat;
    end

    // Parity cell chain
    for (genvar j = 0; j < MAX_PARITY; j++) begin : g_cell
        byte_t prev;
        if (j == 0) begin : g_first
            assign prev = '0;
        end else begin : g_rest
            assign prev = stages[j-1];
        end
        rsse_cell u_cell (
            .aclk    (aclk),
            .ctrl    (ctrl),
            .en      (IDX_W'(j) <= top_reg),
            .prev    (prev),
            .fb      (fb),
            .coef_in (GEN_TABLE[coef_idx][j]),
            .stage   (stages[j])
        );
    end

    // Sequencing and output register
    always_comb begin
        top_next      = top_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        draining_next = draining_reg;
        left_next     = left_reg;
        drain_tl_next = drain_tl_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_code_next   = m_code_reg;
        m_par_next    = m_par_reg;
        m_last_next   = m_last_reg;
        m_tl_next     = m_tl_reg;

        if (cfg_beat) begin
            top_next = eff_top(cfg_parity_count);
        end

        if (in_beat) begin
            m_valid_next = 1'b1;
            m_code_next  = s_data_byte;
            m_par_next   = 1'b0;
            m_last_next  = 1'b0;
            m_tl_next    = tl;
            if (s_last_of_message) begin
                count_next    = '0;
                ovf_next      = 1'b0;
                draining_next = 1'b1;
                left_next     = CNT_W'(top_reg) + CNT_W'(1);
                drain_tl_next = tl;
            end else begin
                count_next = count_inc;
                ovf_next   = tl;
            end
        end else if (par_beat) begin
            m_valid_next = 1'b1;
            m_code_next  = stages[top_reg];
            m_par_next   = 1'b1;
            m_last_next  = final_beat;
            m_tl_next    = drain_tl_reg;
            left_next    = left_reg - CNT_W'(1);
            if (final_beat) begin
                draining_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_reg      <= eff_top(PARITY_RESET);
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            draining_reg <= 1'b0;
            left_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            top_reg      <= top_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            draining_reg <= draining_next;
            left_reg     <= left_next;
            m_valid_reg  <= m_valid_next;
        end
        drain_tl_reg <= drain_tl_next;
        m_code_reg   <= m_code_next;
        m_par_reg    <= m_par_next;
        m_last_reg   <= m_last_next;
        m_tl_reg     <= m_tl_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_code_byte        = m_code_reg;
    assign m_is_parity        = m_par_reg;
    assign m_last_of_codeword = m_last_reg;
    assign m_too_long         = m_tl_reg;

endmodule

FILE: tb/reed_solomon_systematic_encoder_unit_tb.sv
module reed_solomon_systematic_encoder_unit_tb;
    import rsse_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // One beat of the codeword stream
    typedef struct packed {
        logic [7:0] code;
        logic       parity;
        logic       last_cw;
        logic       too_long;
    } code_beat_t;

    localparam int MAX_REPORTS = 10;
    localparam int HOLD_CYCLES = 150;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [7:0]       s_data_byte = 8'h00;
    logic             s_last_of_message = 1'b0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [7:0]       m_code_byte;
    logic             m_is_parity;
    logic             m_last_of_codeword;
    logic             m_too_long;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_parity_count = PARITY_RESET;

    reed_solomon_systematic_encoder_unit dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_data_byte        (s_data_byte),
        .s_last_of_message  (s_last_of_message),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_code_byte        (m_code_byte),
        .m_is_parity        (m_is_parity),
        .m_last_of_codeword (m_last_of_codeword),
        .m_too_long         (m_too_long),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_parity_count   (cfg_parity_count)
    );

    always #10 aclk = ~aclk;

    // Encoder state as the testbench predicts it
    logic [CFG_W-1:0] parity_setting;
    logic [7:0]       parity_stage [MAX_PARITY];
    logic [7:0]       generator_coef [MAX_PARITY+1];
    logic [7:0]       symbols_in_message;
    logic             overlong;

    code_beat_t codeword_q [$];

    // Traffic knobs and counters
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;
    int mismatch_count = 0;
    int beats_checked = 0;
    int bytes_sent = 0;
    int codewords_sent = 0;
    int cfg_writes = 0;

    // GF(2^8) product, field polynomial 0x11d
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] prod;
        logic [7:0] m;
        prod = 8'h00;
        m    = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                prod = prod ^ m;
            end
            m = {m[6:0], 1'b0} ^ (m[7] ? FIELD_POLY_LOW : 8'h00);
        end
        return prod;
    endfunction

    // Parity count clamped to 1..MAX_PARITY
    function automatic int active_parity(input logic [CFG_W-1:0] pc);
        if (pc == '0) begin
            return 1;
        end else if (int'(pc) > MAX_PARITY) begin
            return MAX_PARITY;
        end
        return int'(pc);
    endfunction

    // g(x) = (x + a^0)(x + a^1)...(x + a^(n-1))
    function automatic void build_generator();
        int         n;
        logic [7:0] root;
        n    = active_parity(parity_setting);
        root = 8'h01;
        for (int k = 0; k <= MAX_PARITY; k++) begin
            generator_coef[k] = 8'h00;
        end
        generator_coef[0] = 8'h01;
        for (int i = 0; i < n; i++) begin
            for (int k = i + 1; k > 0; k--) begin
                generator_coef[k] = generator_coef[k-1] ^ gf_mul(generator_coef[k], root);
            end
            generator_coef[0] = gf_mul(generator_coef[0], root);
            root = gf_mul(root, 8'h02);
        end
    endfunction

    function automatic void clear_codeword();
        for (int k = 0; k < MAX_PARITY; k++) begin
            parity_stage[k] = 8'h00;
        end
        symbols_in_message = 8'h00;
        overlong = 1'b0;
    endfunction

    // Clock one message byte into the LFSR and queue the beats it produces
    function automatic void encode_symbol(input logic [7:0] d, input logic last_sym);
        int         n;
        logic [7:0] fb;
        n = active_parity(parity_setting);
        if (symbols_in_message < FIELD_LIMIT) begin
            symbols_in_message = symbols_in_message + 8'd1;
        end
        if (int'(symbols_in_message) > 255 - n) begin
            overlong = 1'b1;
        end
        fb = d ^ parity_stage[n-1];
        for (int j = n - 1; j > 0; j--) begin
            parity_stage[j] = parity_stage[j-1] ^ gf_mul(fb, generator_coef[j]);
        end
        parity_stage[0] = gf_mul(fb, generator_coef[0]);
        codeword_q.push_back('{code: d, parity: 1'b0, last_cw: 1'b0, too_long: overlong});
        if (last_sym) begin
            for (int j = n; j > 0; j--) begin
                codeword_q.push_back('{code: parity_stage[j-1], parity: 1'b1,
                                       last_cw: (j == 1), too_long: overlong});
            end
            clear_codeword();
            codewords_sent++;
        end
    endfunction

    // Result side: random stalls, long hold-offs, and the check of each beat
    always @(posedge aclk) begin : result_side
        code_beat_t got;
        code_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{code: m_code_byte, parity: m_is_parity,
                    last_cw: m_last_of_codeword, too_long: m_too_long};
            if (codeword_q.size() == 0) begin
                if (mismatch_count < MAX_REPORTS) begin
                    $display("%0t: unexpected beat code=%02h par=%b last=%b long=%b",
                             $realtime, got.code, got.parity, got.last_cw, got.too_long);
                end
                mismatch_count++;
            end else begin
                want = codeword_q.pop_front();
                beats_checked++;
                if (got.code !== want.code || got.parity !== want.parity ||
                    got.last_cw !== want.last_cw || got.too_long !== want.too_long) begin
                    if (mismatch_count < MAX_REPORTS) begin
                        $display("%0t: beat %0d exp code=%02h par=%b last=%b long=%b",
                                 $realtime, beats_checked, want.code, want.parity,
                                 want.last_cw, want.too_long);
                        $display("%0t: beat %0d got code=%02h par=%b last=%b long=%b",
                                 $realtime, beats_checked, got.code, got.parity,
                                 got.last_cw, got.too_long);
                    end
                    mismatch_count++;
                end
            end
        end
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic set_traffic(input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
    endtask

    // Offer one message byte; valid stays up across back-to-back bytes
    task automatic send_symbol(input logic [7:0] d, input logic last_sym);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid           <= 1'b1;
        s_data_byte       <= d;
        s_last_of_message <= last_sym;
        do @(posedge aclk); while (!s_ready);
        encode_symbol(d, last_sym);
        bytes_sent++;
    endtask

    task automatic send_message(input int len);
        for (int k = 0; k < len; k++) begin
            send_symbol(8'($urandom_range(255)), k == len - 1);
        end
    endtask

    // Stop offering and wait for every predicted beat
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (codeword_q.size() != 0);
    endtask

    task automatic write_parity_count(input logic [CFG_W-1:0] value);
        wait_drained();
        repeat (3) @(posedge aclk);
        cfg_valid        <= 1'b1;
        cfg_parity_count <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        parity_setting = value;
        build_generator();
        cfg_writes++;
    endtask

    // Edge byte values and every parity-count extreme, including the clamped ones
    task automatic test_directed_extremes();
        set_traffic(0, 0);
        send_symbol(8'h00, 1'b1);
        send_symbol(8'hff, 1'b1);
        send_symbol(8'h01, 1'b0);
        send_symbol(8'h80, 1'b0);
        send_symbol(8'h55, 1'b0);
        send_symbol(8'haa, 1'b1);
        write_parity_count(CFG_W'(0));
        send_symbol(8'hff, 1'b1);
        send_symbol(8'h12, 1'b0);
        send_symbol(8'h34, 1'b1);
        write_parity_count(CFG_W'(63));
        send_symbol(8'ha5, 1'b1);
        send_symbol(8'h5a, 1'b0);
        send_symbol(8'hff, 1'b1);
        write_parity_count(CFG_W'(33));
        send_symbol(8'h01, 1'b1);
        write_parity_count(CFG_W'(32));
        send_symbol(8'hff, 1'b0);
        send_symbol(8'h00, 1'b1);
        write_parity_count(CFG_W'(1));
        send_symbol(8'h80, 1'b1);
        send_symbol(8'h7f, 1'b0);
        send_symbol(8'h01, 1'b1);
    endtask

    // New count applies at once; stages above it hold until the codeword ends
    task automatic test_parity_count_change_mid_codeword();
        set_traffic(0, 0);
        write_parity_count(CFG_W'(16));
        for (int k = 0; k < 5; k++) send_symbol(8'($urandom_range(255)), 1'b0);
        write_parity_count(CFG_W'(4));
        for (int k = 0; k < 2; k++) send_symbol(8'($urandom_range(255)), 1'b0);
        write_parity_count(CFG_W'(16));
        send_symbol(8'($urandom_range(255)), 1'b0);
        send_symbol(8'($urandom_range(255)), 1'b1);
        write_parity_count(CFG_W'(3));
        send_symbol(8'($urandom_range(255)), 1'b0);
        send_symbol(8'($urandom_range(255)), 1'b0);
        write_parity_count(CFG_W'(9));
        send_symbol(8'($urandom_range(255)), 1'b1);
    endtask

    // Message past 255 - n bytes: flag on the crossing byte and all later beats of that codeword
    task automatic test_too_long();
        set_traffic(0, 0);
        write_parity_count(CFG_W'(32));
        send_message(225);
        write_parity_count(CFG_W'(2));
        send_message(3);
    endtask

    // Long receiver hold-off to fill the block, then a full pause of the sender
    task automatic test_backpressure();
        set_traffic(0, 0);
        write_parity_count(CFG_W'(8));
        hold_request = HOLD_CYCLES;
        for (int m = 0; m < 8; m++) send_message(5);
        wait_drained();
        for (int m = 0; m < 3; m++) send_message($urandom_range(1, 6));
    endtask

    task automatic random_phase(input int idle_pct, input int stall_pct, input int n_bytes);
        int sent;
        int len;
        set_traffic(idle_pct, stall_pct);
        write_parity_count(CFG_W'($urandom_range(63)));
        sent = 0;
        while (sent < n_bytes) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
            send_message(len);
            sent += len;
            if (sent >= n_bytes / 2 && sent - len < n_bytes / 2) begin
                write_parity_count(CFG_W'($urandom_range(63)));
            end
        end
    endtask

    task automatic test_random_traffic();
        random_phase(0, 0, 40);
        random_phase(52, 0, 40);
        random_phase(0, 52, 40);
        random_phase(36, 36, 40);
    endtask

    initial begin : main
        int guard;
        parity_setting = PARITY_RESET;
        build_generator();
        clear_codeword();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_extremes();
        test_parity_count_change_mid_codeword();
        test_too_long();
        test_backpressure();
        test_random_traffic();

        // Drain whatever is still in flight, then let the pipeline settle
        s_valid <= 1'b0;
        guard = 0;
        while (codeword_q.size() != 0 && guard < 100000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (40) @(posedge aclk);

        $display("Encoded %0d message bytes in %0d codewords, %0d output beats checked,",
                 bytes_sent, codewords_sent, beats_checked);
        $display("%0d parity-count writes incl. 0, 1, 32, 33, 63 and mid-codeword changes.",
                 cfg_writes);
        if (codeword_q.size() != 0) begin
            $display("%0d predicted beats never arrived", codeword_q.size());
        end
        if (mismatch_count == 0 && codeword_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Hang guard
    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
